// ===== src/cwg_pkg.sv =====
// ----------------------------------------------------------------------------
// cwg_pkg
// shared constants, types and cordic helpers for the circle waypoint generator
// ----------------------------------------------------------------------------
package cwg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_POINTS        = 4096;

  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;
  localparam int IDX_W   = 13;
  localparam int CNT_W   = 13;
  localparam int ANG_W   = 16;
  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;

  // reciprocal of the count is 2^RECIP_SHIFT / count
  localparam int RECIP_SHIFT = 45;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
  localparam logic [31:0]        NEAR_X_LIMIT    = 32'd1063004405;

  typedef enum logic [CIDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_CENTER_Z    = 3'd2,
    REG_RADIUS      = 3'd3,
    REG_INCLINATION = 3'd4,
    REG_AZIMUTH     = 3'd5,
    REG_POINT_COUNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         q;
  } cord_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sincos_t;

  typedef struct packed {
    logic signed [31:0]   ux;
    logic signed [31:0]   uy;
    logic signed [31:0]   uz;
    logic signed [31:0]   vx;
    logic signed [31:0]   vy;
    logic signed [31:0]   vz;
    logic [RECIP_W-1:0]   recip;
  } frame_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // quadrant fold and start vector
  function automatic cord_t cord_pre(input logic [31:0] a);
    logic [31:0] t;
    logic [31:0] d;
    cord_t       r;
    t   = a + 32'h2000_0000;
    r.q = t[31:30];
    d   = a - {t[31:30], 30'd0};
    r.z = $signed({d[31], d});
    r.x = CORDIC_GAIN_INV;
    r.y = 34'sd0;
    return r;
  endfunction

  // one rotation step
  function automatic cord_t cord_step(input cord_t c, input int sh);
    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [32:0] at;
    cord_t              r;
    sx  = c.x >>> sh;
    sy  = c.y >>> sh;
    at  = $signed({1'b0, atan_turn(sh)});
    r.q = c.q;
    if (!c.z[32]) begin
      r.x = c.x - sy;
      r.y = c.y + sx;
      r.z = c.z - at;
    end else begin
      r.x = c.x + sy;
      r.y = c.y - sx;
      r.z = c.z + at;
    end
    return r;
  endfunction

  // quadrant unfold
  function automatic sincos_t cord_post(input cord_t c);
    sincos_t            r;
    logic signed [33:0] nx;
    logic signed [33:0] ny;
    nx = -c.x;
    ny = -c.y;
    case (c.q)
      2'd0: begin
        r.c = 32'(c.x);
        r.s = 32'(c.y);
      end
      2'd1: begin
        r.c = 32'(ny);
        r.s = 32'(c.x);
      end
      2'd2: begin
        r.c = 32'(nx);
        r.s = 32'(ny);
      end
      default: begin
        r.c = 32'(c.y);
        r.s = 32'(nx);
      end
    endcase
    return r;
  endfunction

endpackage

// ===== src/cwg_cordic.sv =====
// ----------------------------------------------------------------------------
// cwg_cordic
// fully pipelined sine / cosine of a 32-bit turn fraction
// ----------------------------------------------------------------------------
module cwg_cordic #(
  parameter int STAGES = cwg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [31:0]         phase,
  output logic                out_vld,
  output cwg_pkg::sincos_t    sc
);

  cwg_pkg::cord_t   st_r [0:STAGES];
  logic [STAGES:0]  vld_r;
  cwg_pkg::sincos_t sc_r;
  logic             out_vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= cwg_pkg::cord_pre(phase);
      for (int i = 0; i < STAGES; i++) begin
        st_r[i+1] <= cwg_pkg::cord_step(st_r[i], i);
      end
      sc_r <= cwg_pkg::cord_post(st_r[STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[STAGES-1:0], in_vld};
      out_vld_r <= vld_r[STAGES];
    end
  end

  assign sc      = sc_r;
  assign out_vld = out_vld_r;

endmodule

// ===== src/cwg_frame.sv =====
// ----------------------------------------------------------------------------
// cwg_frame
// sequential solver for the circle frame (u, v) and the count reciprocal
// ----------------------------------------------------------------------------
module cwg_frame #(
  parameter int STAGES = cwg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cwg_pkg::ANG_W-1:0]    inclination,
  input  logic [cwg_pkg::ANG_W-1:0]    azimuth,
  input  logic [cwg_pkg::CNT_W-1:0]    count,
  output logic                         busy,
  output cwg_pkg::frame_t              frame
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLOAD, ST_CITER, ST_NMUL, ST_WMUL, ST_SQMUL,
    ST_SQRT, ST_DLOAD, ST_DITER, ST_VMUL
  } state_t;

  state_t             state_r;
  logic               ang_sel_r;
  logic [2:0]         k_r;
  logic [6:0]         it_r;
  cwg_pkg::cord_t     cs_r;
  logic signed [31:0] ci_r, si_r, ca_r, sa_r;
  logic signed [31:0] n_r [3];
  logic signed [33:0] w_r [3];
  logic signed [31:0] u_r [3];
  logic signed [31:0] v_r [3];
  logic [63:0]        len2_r;
  logic [63:0]        sq_v_r, sq_r_r, sq_bit_r;
  logic [31:0]        len_r;
  logic [32:0]        div_rem_r, div_d_r;
  logic [63:0]        div_n_r, div_q_r;
  logic               div_neg_r;
  logic signed [71:0] acc_r;
  logic [cwg_pkg::RECIP_W-1:0] recip_r;

  logic               near_x;
  logic signed [32:0] n0_ext;
  logic [32:0]        n0_abs;
  logic signed [31:0] p_sel;
  logic [34:0]        w_abs [3];
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] mul_p;
  logic signed [71:0] mul_sra;
  logic signed [71:0] w_calc;
  logic signed [71:0] acc_nxt;
  logic               v_sub;
  logic [64:0]        sq_t;
  logic               sq_ge;
  logic [63:0]        sq_r_nxt;
  logic [33:0]        rem_sh;
  logic               div_ge;
  logic [32:0]        rem_nxt;
  logic [63:0]        q_fin;
  cwg_pkg::cord_t     c_step;
  cwg_pkg::sincos_t   c_post;
  logic [1:0]         kk;

  assign kk     = k_r[1:0];
  assign n0_ext = {n_r[0][31], n_r[0]};
  assign n0_abs = n0_ext[32] ? 33'(-n0_ext) : 33'(n0_ext);
  assign near_x = n0_abs > {1'b0, cwg_pkg::NEAR_X_LIMIT};
  assign p_sel  = near_x ? n_r[1] : n_r[0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_abs[k] = w_r[k][33] ? 35'(-{w_r[k][33], w_r[k]}) : 35'({1'b0, w_r[k]});
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    v_sub = 1'b0;
    case (state_r)
      ST_NMUL: begin
        mul_a = 36'(si_r);
        mul_b = (kk == 2'd0) ? 36'(ca_r) : 36'(sa_r);
      end
      ST_WMUL: begin
        mul_a = 36'(p_sel);
        mul_b = 36'(n_r[kk]);
      end
      ST_SQMUL: begin
        mul_a = $signed({1'b0, w_abs[kk]});
        mul_b = $signed({1'b0, w_abs[kk]});
      end
      ST_VMUL: begin
        case (k_r)
          3'd0: begin mul_a = 36'(n_r[1]); mul_b = 36'(u_r[2]); end
          3'd1: begin mul_a = 36'(n_r[2]); mul_b = 36'(u_r[1]); v_sub = 1'b1; end
          3'd2: begin mul_a = 36'(n_r[2]); mul_b = 36'(u_r[0]); end
          3'd3: begin mul_a = 36'(n_r[0]); mul_b = 36'(u_r[2]); v_sub = 1'b1; end
          3'd4: begin mul_a = 36'(n_r[0]); mul_b = 36'(u_r[1]); end
          default: begin mul_a = 36'(n_r[1]); mul_b = 36'(u_r[0]); v_sub = 1'b1; end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_sra = mul_p >>> 30;
  assign w_calc  = (72'sd0 - mul_sra) +
                   ((kk == {1'b0, near_x}) ? 72'(cwg_pkg::ONE_Q30) : 72'sd0);
  assign acc_nxt = v_sub ? (acc_r - mul_p) : (acc_r + mul_p);

  // digit-by-digit square root step
  assign sq_t     = {1'b0, sq_r_r} + {1'b0, sq_bit_r};
  assign sq_ge    = {1'b0, sq_v_r} >= sq_t;
  assign sq_r_nxt = sq_ge ? ((sq_r_r >> 1) + sq_bit_r) : (sq_r_r >> 1);

  // restoring divider step
  assign rem_sh  = {div_rem_r, div_n_r[63]};
  assign div_ge  = rem_sh >= {1'b0, div_d_r};
  assign rem_nxt = div_ge ? 33'(rem_sh - {1'b0, div_d_r}) : rem_sh[32:0];
  assign q_fin   = {div_q_r[62:0], div_ge};

  assign c_step = cwg_pkg::cord_step(cs_r, int'(it_r));
  assign c_post = cwg_pkg::cord_post(c_step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLOAD;
      ang_sel_r <= 1'b0;
      k_r       <= '0;
      it_r      <= '0;
    end else if (start) begin
      state_r   <= ST_CLOAD;
      ang_sel_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLOAD: begin
          cs_r    <= cwg_pkg::cord_pre(ang_sel_r ? {azimuth, 16'd0} : {inclination, 16'd0});
          it_r    <= '0;
          state_r <= ST_CITER;
        end
        ST_CITER: begin
          cs_r <= c_step;
          it_r <= it_r + 7'd1;
          if (int'(it_r) == STAGES - 1) begin
            if (!ang_sel_r) begin
              ci_r      <= c_post.c;
              si_r      <= c_post.s;
              ang_sel_r <= 1'b1;
              state_r   <= ST_CLOAD;
            end else begin
              ca_r    <= c_post.c;
              sa_r    <= c_post.s;
              k_r     <= '0;
              state_r <= ST_NMUL;
            end
          end
        end
        ST_NMUL: begin
          n_r[kk] <= 32'(mul_sra);
          if (kk == 2'd1) begin
            n_r[2]  <= ci_r;
            k_r     <= '0;
            state_r <= ST_WMUL;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        ST_WMUL: begin
          w_r[kk] <= 34'(w_calc);
          if (kk == 2'd2) begin
            k_r     <= '0;
            len2_r  <= '0;
            state_r <= ST_SQMUL;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        ST_SQMUL: begin
          len2_r <= len2_r + mul_p[63:0];
          if (kk == 2'd2) begin
            sq_v_r   <= len2_r + mul_p[63:0];
            sq_r_r   <= '0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
            it_r     <= '0;
            state_r  <= ST_SQRT;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            sq_v_r <= sq_v_r - sq_t[63:0];
          end
          sq_r_r   <= sq_r_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          it_r     <= it_r + 7'd1;
          if (it_r == 7'd31) begin
            len_r   <= sq_r_nxt[31:0];
            k_r     <= '0;
            state_r <= ST_DLOAD;
          end
        end
        ST_DLOAD: begin
          div_rem_r <= '0;
          div_q_r   <= '0;
          it_r      <= '0;
          if (k_r == 3'd3) begin
            div_n_r   <= 64'd1 << cwg_pkg::RECIP_SHIFT;
            div_d_r   <= 33'(count);
            div_neg_r <= 1'b0;
            state_r   <= ST_DITER;
          end else if (len_r == 32'd0) begin
            // zero-length axis: fall back to the reference axis
            case (kk)
              2'd0:    u_r[0] <= near_x ? 32'sd0 : cwg_pkg::ONE_Q30;
              2'd1:    u_r[1] <= near_x ? cwg_pkg::ONE_Q30 : 32'sd0;
              default: u_r[2] <= 32'sd0;
            endcase
            k_r <= k_r + 3'd1;
          end else begin
            div_n_r   <= (64'(w_abs[kk]) << 30) + 64'(len_r[31:1]);
            div_d_r   <= {1'b0, len_r};
            div_neg_r <= w_r[kk][33];
            state_r   <= ST_DITER;
          end
        end
        ST_DITER: begin
          div_rem_r <= rem_nxt;
          div_n_r   <= div_n_r << 1;
          div_q_r   <= q_fin;
          it_r      <= it_r + 7'd1;
          if (it_r == 7'd63) begin
            if (k_r == 3'd3) begin
              recip_r <= q_fin[cwg_pkg::RECIP_W-1:0];
              k_r     <= '0;
              acc_r   <= '0;
              state_r <= ST_VMUL;
            end else begin
              u_r[kk] <= div_neg_r ? 32'(-q_fin) : q_fin[31:0];
              k_r     <= k_r + 3'd1;
              state_r <= ST_DLOAD;
            end
          end
        end
        ST_VMUL: begin
          if (k_r[0]) begin
            v_r[k_r[2:1]] <= 32'(acc_nxt >>> 30);
            acc_r         <= '0;
          end else begin
            acc_r <= acc_nxt;
          end
          if (k_r == 3'd5) begin
            state_r <= ST_IDLE;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign frame.ux    = u_r[0];
  assign frame.uy    = u_r[1];
  assign frame.uz    = u_r[2];
  assign frame.vx    = v_r[0];
  assign frame.vy    = v_r[1];
  assign frame.vz    = v_r[2];
  assign frame.recip = recip_r;

endmodule

// ===== src/cwg_place.sv =====
// ----------------------------------------------------------------------------
// cwg_place
// projects cos/sin onto the frame, scales by radius and adds the center
// ----------------------------------------------------------------------------
module cwg_place (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  cwg_pkg::sincos_t               sc,
  input  cwg_pkg::frame_t                frame,
  input  logic [cwg_pkg::RAD_W-1:0]      radius,
  input  logic signed [cwg_pkg::POS_W-1:0] center_x,
  input  logic signed [cwg_pkg::POS_W-1:0] center_y,
  input  logic signed [cwg_pkg::POS_W-1:0] center_z,
  output logic                           out_vld,
  output logic signed [cwg_pkg::POS_W-1:0] pos_x,
  output logic signed [cwg_pkg::POS_W-1:0] pos_y,
  output logic signed [cwg_pkg::POS_W-1:0] pos_z
);

  logic signed [31:0] u_w [3];
  logic signed [31:0] v_w [3];
  logic signed [31:0] cen [3];

  logic signed [63:0] pa_r [3];
  logic signed [63:0] pb_r [3];
  logic signed [33:0] d_r  [3];
  logic signed [65:0] mr_r [3];
  logic signed [31:0] pos_r [3];
  logic [3:0]         vld_r;

  logic signed [64:0] sum   [3];
  logic signed [65:0] rnd   [3];
  logic signed [65:0] pt    [3];
  logic signed [31:0] sat   [3];
  logic signed [32:0] rad_s;

  assign u_w[0] = frame.ux;
  assign u_w[1] = frame.uy;
  assign u_w[2] = frame.uz;
  assign v_w[0] = frame.vx;
  assign v_w[1] = frame.vy;
  assign v_w[2] = frame.vz;
  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;
  assign rad_s  = $signed({2'b00, radius});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = 65'(pa_r[k]) + 65'(pb_r[k]);
      rnd[k] = (mr_r[k] + (66'sd1 <<< 29)) >>> 30;
      pt[k]  = rnd[k] + 66'(cen[k]);
      if (pt[k] > 66'sd2147483647) begin
        sat[k] = 32'sh7fff_ffff;
      end else if (pt[k] < -66'sd2147483648) begin
        sat[k] = 32'sh8000_0000;
      end else begin
        sat[k] = 32'(pt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_r[k]  <= sc.c * u_w[k];
        pb_r[k]  <= sc.s * v_w[k];
        d_r[k]   <= 34'(sum[k] >>> 30);
        mr_r[k]  <= rad_s * d_r[k];
        pos_r[k] <= sat[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  assign out_vld = vld_r[3];
  assign pos_x   = pos_r[0];
  assign pos_y   = pos_r[1];
  assign pos_z   = pos_r[2];

endmodule

// ===== src/circle_waypoint_generator_unit.sv =====
// ----------------------------------------------------------------------------
// circle_waypoint_generator_unit
// maps a waypoint index to a point on a configured circle in 3D space
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake            payload
//   in_         request    in_valid / in_stall   in_point_index
//   out_        result     out_valid / out_stall out_pos_x, out_pos_y, out_pos_z
//   cfg_        write      cfg_we                cfg_index, cfg_wdata
//
// one request per cycle while in_stall is low; the pipe has 3 phase stages,
// a cordic pipe of CORDIC_STAGES + 2 and 4 placement stages
// after reset and after any write of inclination, azimuth or the point count
// the frame solver runs with in_stall high (two serial cordic runs, a
// 32-step square root, up to four 64-step divides)
// out_stall freezes the whole pipe while out_valid is high
// the last stage is the output register; reset is synchronous, active low,
// and clears control state and the configuration registers
module circle_waypoint_generator_unit #(
  parameter int CORDIC_STAGES = cwg_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cwg_pkg::IDX_W-1:0]         in_point_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cwg_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [cwg_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [cwg_pkg::POS_W-1:0]  out_pos_z,
  input  logic                              cfg_we,
  input  logic [cwg_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [cwg_pkg::CFG_W-1:0]         cfg_wdata
);

  // configuration registers
  logic signed [31:0]               center_x_r, center_y_r, center_z_r;
  logic [cwg_pkg::RAD_W-1:0]        radius_r;
  logic [cwg_pkg::ANG_W-1:0]        inclination_r, azimuth_r;
  logic [cwg_pkg::CNT_W-1:0]        count_r;
  logic [cwg_pkg::CNT_W-1:0]        cnt_eff;
  logic                             frame_start;

  // pipe control
  logic                             adv;
  logic                             in_acc;
  logic                             busy;
  cwg_pkg::frame_t                  frame;

  // phase stages
  logic                             p1_vld_r, p2_vld_r, p3_vld_r;
  logic [cwg_pkg::IDX_W+cwg_pkg::RECIP_W-1:0] prod1_r;
  logic [31:0]                      q0_r;
  logic [31:0]                      phase_r;
  logic [26:0]                      m_full;
  logic [13:0]                      rem_lo;
  logic                             bump;

  logic                             sc_vld;
  cwg_pkg::sincos_t                 sc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r    <= '0;
      center_y_r    <= '0;
      center_z_r    <= '0;
      radius_r      <= '0;
      inclination_r <= '0;
      azimuth_r     <= '0;
      count_r       <= 13'd1;
    end else if (cfg_we) begin
      case (cwg_pkg::reg_idx_t'(cfg_index))
        cwg_pkg::REG_CENTER_X:    center_x_r    <= cfg_wdata;
        cwg_pkg::REG_CENTER_Y:    center_y_r    <= cfg_wdata;
        cwg_pkg::REG_CENTER_Z:    center_z_r    <= cfg_wdata;
        cwg_pkg::REG_RADIUS:      radius_r      <= cfg_wdata[cwg_pkg::RAD_W-1:0];
        cwg_pkg::REG_INCLINATION: inclination_r <= cfg_wdata[cwg_pkg::ANG_W-1:0];
        cwg_pkg::REG_AZIMUTH:     azimuth_r     <= cfg_wdata[cwg_pkg::ANG_W-1:0];
        cwg_pkg::REG_POINT_COUNT: count_r       <= cfg_wdata[cwg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // anything that moves the frame or the reciprocal restarts the solver
  assign frame_start = cfg_we &&
    ((cwg_pkg::reg_idx_t'(cfg_index) == cwg_pkg::REG_INCLINATION) ||
     (cwg_pkg::reg_idx_t'(cfg_index) == cwg_pkg::REG_AZIMUTH) ||
     (cwg_pkg::reg_idx_t'(cfg_index) == cwg_pkg::REG_POINT_COUNT));

  // zero count means one, large counts clip to the point limit
  always_comb begin
    if (count_r == '0) begin
      cnt_eff = 13'd1;
    end else if (32'(count_r) > cwg_pkg::MAX_POINTS) begin
      cnt_eff = 13'(cwg_pkg::MAX_POINTS);
    end else begin
      cnt_eff = count_r;
    end
  end

  cwg_frame #(
    .STAGES (CORDIC_STAGES)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (frame_start),
    .inclination (inclination_r),
    .azimuth     (azimuth_r),
    .count       (cnt_eff),
    .busy        (busy),
    .frame       (frame)
  );

  // whole pipe moves unless the output holds a result that is stalled
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || busy;
  assign in_acc   = in_valid && !in_stall;

  // phase = floor(index * 2^32 / count) mod 2^32
  // estimate via the reciprocal is low by at most one, fixed in stage 3
  assign m_full = 27'(q0_r[13:0]) * 27'(cnt_eff);
  assign rem_lo = 14'd0 - m_full[13:0];
  assign bump   = rem_lo >= {1'b0, cnt_eff};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= (cwg_pkg::IDX_W+cwg_pkg::RECIP_W)'(in_point_index) *
                 (cwg_pkg::IDX_W+cwg_pkg::RECIP_W)'(frame.recip);
      q0_r    <= prod1_r[cwg_pkg::RECIP_SHIFT-1 -: 32];
      phase_r <= q0_r + 32'(bump);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= in_acc;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  cwg_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (p3_vld_r),
    .phase   (phase_r),
    .out_vld (sc_vld),
    .sc      (sc)
  );

  cwg_place u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sc_vld),
    .sc       (sc),
    .frame    (frame),
    .radius   (radius_r),
    .center_x (center_x_r),
    .center_y (center_y_r),
    .center_z (center_z_r),
    .out_vld  (out_valid),
    .pos_x    (out_pos_x),
    .pos_y    (out_pos_y),
    .pos_z    (out_pos_z)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle waypoint generator testbench
// directed and random waypoint requests against a bit-exact point predictor,
// with random idling on both sides, back-pressure and register changes
// ----------------------------------------------------------------------------
module tb;

  // register index with no register behind it, writes to it are dropped
  localparam logic [cwg_pkg::CIDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int PIPE_LATENCY = cwg_pkg::CORDIC_STAGES_DEF + 9;
  localparam int LONG_HOLD    = 300;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  // predicts each waypoint and checks the points coming back in order
  class waypoint_scoreboard;
    longint     cx, cy, cz;
    longint     rad;
    logic [15:0] incl, azim;
    logic [12:0] count_reg;
    point_t     pending_points[$];
    int         errors;
    int         checked;
    longint     turn_step[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                  21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                                  333772, 166886, 83443, 41722, 20861};

    function void clear_regs();
      cx = 0; cy = 0; cz = 0; rad = 0; incl = 0; azim = 0; count_reg = 1;
    endfunction

    function void write_reg(logic [cwg_pkg::CIDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        cwg_pkg::REG_CENTER_X:    cx = longint'($signed(data));
        cwg_pkg::REG_CENTER_Y:    cy = longint'($signed(data));
        cwg_pkg::REG_CENTER_Z:    cz = longint'($signed(data));
        cwg_pkg::REG_RADIUS:      rad = longint'(data[30:0]);
        cwg_pkg::REG_INCLINATION: incl = data[15:0];
        cwg_pkg::REG_AZIMUTH:     azim = data[15:0];
        cwg_pkg::REG_POINT_COUNT: count_reg = data[12:0];
        default: ;
      endcase
    endfunction

    // rotation-mode cordic with quadrant fold, Q2.30 out
    function void sin_cos(logic [31:0] a, output longint c, output longint s);
      logic [31:0] q, d;
      longint x, y, z, nx;
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      d = a - (q << 30);
      z = longint'($signed(d));
      x = 652032874;
      y = 0;
      for (int i = 0; i < cwg_pkg::CORDIC_STAGES_DEF; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - turn_step[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + turn_step[i];
        end
        x = nx;
      end
      case (q[1:0])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint scale_unit(longint w, longint unsigned len);
      longint unsigned mag, q;
      mag = (w < 0) ? -w : w;
      q = ((mag << 30) + len / 2) / len;
      return (w < 0) ? -longint'(q) : longint'(q);
    endfunction

    function logic signed [31:0] place(longint ctr, longint dir);
      longint p;
      p = ctr + ((rad * dir + (64'sd1 <<< 29)) >>> 30);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p[31:0];
    endfunction

    function void note_request(logic [12:0] idx);
      longint unsigned cnt, phase, len2, len;
      longint ci, si, ca, sa, ct, st, p;
      longint n[3], w[3], u[3], v[3];
      logic near_x;
      point_t pt;
      cnt = count_reg;
      if (cnt == 0) cnt = 1;
      if (cnt > cwg_pkg::MAX_POINTS) cnt = cwg_pkg::MAX_POINTS;
      sin_cos({incl, 16'd0}, ci, si);
      sin_cos({azim, 16'd0}, ca, sa);
      phase = (longint'(idx) << 32) / cnt;
      sin_cos(phase[31:0], ct, st);
      n[0] = (si * ca) >>> 30;
      n[1] = (si * sa) >>> 30;
      n[2] = ci;
      near_x = ((n[0] < 0) ? -n[0] : n[0]) > longint'(cwg_pkg::NEAR_X_LIMIT);
      p = near_x ? n[1] : n[0];
      for (int k = 0; k < 3; k++) w[k] = -((p * n[k]) >>> 30);
      w[near_x ? 1 : 0] += longint'(cwg_pkg::ONE_Q30);
      len2 = 0;
      for (int k = 0; k < 3; k++) len2 += (w[k] < 0 ? -w[k] : w[k]) * (w[k] < 0 ? -w[k] : w[k]);
      len = root_floor(len2);
      if (len == 0) begin
        u[0] = near_x ? 0 : longint'(cwg_pkg::ONE_Q30);
        u[1] = near_x ? longint'(cwg_pkg::ONE_Q30) : 0;
        u[2] = 0;
      end else begin
        for (int k = 0; k < 3; k++) u[k] = scale_unit(w[k], len);
      end
      v[0] = (n[1] * u[2] - n[2] * u[1]) >>> 30;
      v[1] = (n[2] * u[0] - n[0] * u[2]) >>> 30;
      v[2] = (n[0] * u[1] - n[1] * u[0]) >>> 30;
      pt.x = place(cx, (ct * u[0] + st * v[0]) >>> 30);
      pt.y = place(cy, (ct * u[1] + st * v[1]) >>> 30);
      pt.z = place(cz, (ct * u[2] + st * v[2]) >>> 30);
      pending_points.insert(pending_points.size(), pt);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_t pt;
      if (pending_points.size() == 0) begin
        report("unexpected point, x", x, 32'd0);
        return;
      end
      pt = pending_points.pop_front();
      checked++;
      if (x !== pt.x) report("pos_x", x, pt.x);
      if (y !== pt.y) report("pos_y", y, pt.y);
      if (z !== pt.z) report("pos_z", z, pt.z);
    endtask
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [cwg_pkg::IDX_W-1:0]   in_point_index;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [31:0]          out_pos_x, out_pos_y, out_pos_z;
  logic                        cfg_we;
  logic [cwg_pkg::CIDX_W-1:0]  cfg_index;
  logic [cwg_pkg::CFG_W-1:0]   cfg_wdata;

  waypoint_scoreboard sb;
  bit hold_req;
  int cfg_writes;

  circle_waypoint_generator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_point_index(in_point_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one, often none
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one request and hold it until accepted
  task send_point(logic [12:0] idx, int gap);
    in_valid       <= 1'b1;
    in_point_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(idx);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause until every point has come back
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // registers only change with the pipe empty, the caller drops cfg_we after the last write
  task write_reg(logic [cwg_pkg::CIDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  task set_circle(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r,
                  logic [15:0] inc, logic [15:0] az, logic [12:0] cnt);
    drain();
    write_reg(cwg_pkg::REG_CENTER_X, x);
    write_reg(cwg_pkg::REG_CENTER_Y, y);
    write_reg(cwg_pkg::REG_CENTER_Z, z);
    write_reg(cwg_pkg::REG_RADIUS, r);
    write_reg(cwg_pkg::REG_INCLINATION, {16'($urandom), inc});
    write_reg(cwg_pkg::REG_AZIMUTH, {16'($urandom), az});
    write_reg(cwg_pkg::REG_POINT_COUNT, {19'($urandom), cnt});
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_center();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_radius();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return $urandom;
      default: return $urandom_range(32'h0040_0000);
    endcase
  endfunction

  function automatic logic [12:0] pick_count();
    case ($urandom_range(7))
      0: return 13'd0;
      1: return 13'($urandom_range(4097, 8191));
      2: return 13'd4096;
      3: return 13'd1;
      default: return 13'($urandom_range(2, 400));
    endcase
  endfunction

  // receiver: check accepted points, stall in random stretches
  initial begin : receiver
    int left;
    int hold;
    left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_pos_x, out_pos_y, out_pos_z);
      if (hold_req) begin
        // long hold, counted here, while the sender keeps offering
        hold_req = 1'b0;
        out_stall <= 1'b1;
        hold = LONG_HOLD;
        left = 0;
      end else if (hold > 0) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        case ($urandom_range(9))
          0, 1, 2: begin out_stall <= 1'b0; left = $urandom_range(5, 40); end
          3:       begin out_stall <= 1'b1; left = $urandom_range(10, 40); end
          default: begin out_stall <= 1'($urandom_range(1)); left = pick_gap(); end
        endcase
      end
    end
  end

  initial begin : limit
    #20ms;
    $display("[circle_waypoint_generator_unit] ERROR");
    $finish;
  end

  initial begin : main
    logic [12:0] cnt_eff;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_index = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_req = 1'b0;
    cfg_writes = 0;
    sb = new();
    sb.clear_regs();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero radius, single waypoint
    send_point(13'd0, 0);
    send_point(13'd1, 1);

    // unit circle in the xy plane, eight points plus wrapping indexes
    set_circle(32'd0, 32'd0, 32'd0, 32'h0001_0000, 16'd0, 16'd0, 13'd8);
    for (int i = 0; i < 9; i++) send_point(13'(i), 0);
    send_point(13'h1FFF, 0);
    send_point(13'd4096, 2);

    // normal on x so the y axis is used, zero count taken as one
    set_circle(32'h0010_0000, 32'hFFF0_0000, 32'd5, 32'h0003_0000, 16'h4000, 16'd0, 13'd0);
    send_point(13'd0, 0);
    send_point(13'd3, 0);
    // unknown register index leaves everything alone
    drain();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_point(13'd1, 0);

    // count above the maximum, saturation at both ends
    set_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               16'hFFFF, 16'hFFFF, 13'h1FFF);
    send_point(13'd0, 0);
    send_point(13'd1024, 0);
    send_point(13'd2048, 0);
    send_point(13'd4095, 0);
    send_point(13'h1FFF, 0);
    set_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               16'h2000, 16'h6000, 13'd4096);
    send_point(13'd0, 0);
    send_point(13'd2048, 0);

    // random circles, mostly indexes within one turn
    for (int ph = 0; ph < 9; ph++) begin
      set_circle(pick_center(), pick_center(), pick_center(), pick_radius(),
                 16'($urandom), 16'($urandom), pick_count());
      cnt_eff = (sb.count_reg == 0) ? 13'd1 :
                (sb.count_reg > cwg_pkg::MAX_POINTS) ? 13'(cwg_pkg::MAX_POINTS) :
                sb.count_reg;
      if (ph == 2) hold_req = 1'b1;
      for (int i = 0; i < 160; i++) begin
        if (ph == 2 && i < 80)
          send_point(13'(i % cnt_eff), 0);
        else if ($urandom_range(9) < 8)
          send_point(13'($urandom_range(cnt_eff - 1)), pick_gap());
        else
          send_point(13'($urandom), pick_gap());
        if (ph == 5 && i == 80) drain();
      end
    end

    drain();
    $display("checked %0d waypoints over %0d register writes", sb.checked, cfg_writes);
    $display("covered axis switch, count clamps, index wrap, saturation and back-pressure");
    if (sb.errors == 0 && sb.pending_points.size() == 0)
      $display("[circle_waypoint_generator_unit] OK");
    else
      $display("[circle_waypoint_generator_unit] ERROR");
    $finish;
  end

endmodule
